// ===== design/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants of the direct-mapped cache tag lookup.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned TAG_W         = 32;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned CFG_IDX_W     = 4;
  localparam int unsigned CFG_DATA_W    = 4;
  localparam int unsigned CNT_W         = 32;

  localparam int unsigned MAX_LINES_DEF  = 1024;
  localparam int unsigned ADDR_WIDTH_DEF = 32;

  localparam logic [CFG_DATA_W-1:0] OFFSET_RESET = 4'd4;
  localparam logic [CFG_DATA_W-1:0] INDEX_RESET  = 4'd6;
  localparam logic [CFG_DATA_W-1:0] OFFSET_MAX   = 4'd12;
  localparam logic [CFG_DATA_W-1:0] INDEX_MAX    = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 4'd1;

  // reciprocal division of the index field by the line count
  localparam int unsigned QUO_SHIFT = 2 * IDX_W;
  localparam int unsigned RECIP_W   = QUO_SHIFT + 1;
  localparam int unsigned LINES_K_W = 17;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
  } dmc_req_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } dmc_line_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dmc_qstat_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_LOOKUP,
    BK_COMPARE
  } dmc_bk_state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== design/dmc_if.sv =====
// ----------------------------------------------------------------------------
// dmc_if
// Valid/ready channels of the cache tag lookup: access, result, config.
// ----------------------------------------------------------------------------
interface dmc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface dmc_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        evicted_valid;
  logic [9:0]  line_index;
  logic [31:0] address_tag;
  logic [31:0] hits_so_far;
  logic [31:0] misses_so_far;

  modport source (output valid, output hit, output evicted_valid, output line_index,
                  output address_tag, output hits_so_far, output misses_so_far,
                  input ready);
  modport sink   (input valid, input hit, input evicted_valid, input line_index,
                  input address_tag, input hits_so_far, input misses_so_far,
                  output ready);
endinterface

interface dmc_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [3:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/direct_mapped_cache_tag_lookup_core.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_lookup_core
// Direct-mapped cache tag lookup with valid bits and saturating totals.
// ----------------------------------------------------------------------------
// Each access address is split into offset, index and tag fields by the
// offset_bits and index_bits registers, and the line (index modulo MAX_LINES)
// is looked up: a hit when valid with a matching tag, else a miss that stores
// the tag. A two-stage front pipeline splits addresses into a four-item queue;
// the lookup side handles one item at a time, a line store read and then a
// compare and write back, before it pops the next. An accepted access passes
// the two front stages, the queue, the line store read and the compare before
// its result is registered. After reset the line store is cleared one line per
// cycle, so no access is taken until every line is cleared; config writes are
// always taken and must happen only while the block is idle.
module direct_mapped_cache_tag_lookup_core import dmc_pkg::*; #(
  parameter int unsigned MAX_LINES  = MAX_LINES_DEF,
  parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dmc_in_if.sink     in_if,
  dmc_cfg_if.sink    cfg_if,
  dmc_out_if.source  out_if
);

  localparam int unsigned LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned Q_W    = LINE_W + $bits(dmc_req_t);

  logic              push, pop, clearing;
  dmc_req_t          push_req, head_req;
  logic [LINE_W-1:0] push_line, head_line;
  logic [Q_W-1:0]    head_data;
  dmc_qstat_t        qstat;

  dmc_front #(.MAX_LINES(MAX_LINES), .ADDR_WIDTH(ADDR_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_if    (cfg_if),
    .clearing  (clearing),
    .qstat     (qstat),
    .push      (push),
    .push_req  (push_req),
    .push_line (push_line)
  );

  dmc_queue #(.WIDTH(Q_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_line, push_req}),
    .pop       (pop),
    .head_data (head_data),
    .qstat     (qstat)
  );

  assign head_line = head_data[Q_W-1 -: LINE_W];
  assign head_req  = head_data[$bits(dmc_req_t)-1:0];

  dmc_back #(.MAX_LINES(MAX_LINES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_line (head_line),
    .head_req  (head_req),
    .qstat     (qstat),
    .pop       (pop),
    .clearing  (clearing),
    .out_if    (out_if)
  );

endmodule

// ===== design/dmc_front.sv =====
// ----------------------------------------------------------------------------
// dmc_front
// Config registers and address split: offset, index and tag fields, then the
// line number as index modulo the line count. Two-stage pipeline into queue.
// ----------------------------------------------------------------------------
module dmc_front import dmc_pkg::*; #(
  parameter int unsigned MAX_LINES  = MAX_LINES_DEF,
  parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF,
  localparam int unsigned LINE_W    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  dmc_in_if.sink            in_if,
  dmc_cfg_if.sink           cfg_if,
  input  logic              clearing,
  input  dmc_qstat_t        qstat,
  output logic              push,
  output dmc_req_t          push_req,
  output logic [LINE_W-1:0] push_line
);

  localparam int unsigned AW_EFF = (ADDR_WIDTH < ADDR_W) ? ADDR_WIDTH : ADDR_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (AW_EFF >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << AW_EFF) - 64'd1);
  localparam int unsigned RECIP =
    (MAX_LINES > (1 << IDX_W)) ? 0 : ((1 << QUO_SHIFT) + MAX_LINES - 1) / MAX_LINES;
  localparam logic [RECIP_W-1:0]   RECIP_K = RECIP_W'(RECIP);
  localparam logic [LINES_K_W-1:0] LINES_K = LINES_K_W'(MAX_LINES);

  logic [CFG_DATA_W-1:0] offset_r;
  logic [CFG_DATA_W-1:0] index_r;

  logic                 v1_r, v2_r;
  logic [IDX_W-1:0]     idx1_r, idx2_r;
  logic [TAG_W-1:0]     tag1_r, tag2_r;
  logic [IDX_W-1:0]     quo2_r;

  logic                  en;
  logic                  accept;
  logic [CFG_DATA_W-1:0] ob, ib;
  logic [ADDR_W-1:0]     addr_m, shifted;
  logic [IDX_W-1:0]      idx_nxt;
  logic [TAG_W-1:0]      tag_nxt;
  logic [IDX_W+RECIP_W-1:0]   prod_q;
  logic [IDX_W+LINES_K_W-1:0] prod_m;
  logic [IDX_W-1:0]           rem;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
      index_r  <= INDEX_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_OFFSET_BITS: offset_r <= cfg_if.data;
        CFG_INDEX_BITS:  index_r  <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign en           = !v2_r || !qstat.full;
  assign in_if.ready  = en && !clearing;
  assign accept       = in_if.valid && in_if.ready;

  // field split
  always_comb begin
    ob      = (offset_r > OFFSET_MAX) ? OFFSET_MAX : offset_r;
    ib      = (index_r > INDEX_MAX) ? INDEX_MAX : index_r;
    addr_m  = in_if.address & ADDR_MASK;
    shifted = addr_m >> ob;
    idx_nxt = shifted[IDX_W-1:0] & ~({IDX_W{1'b1}} << ib);
    tag_nxt = shifted >> ib;
  end

  assign prod_q = idx1_r * RECIP_K;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r <= idx_nxt;
      tag1_r <= tag_nxt;
      idx2_r <= idx1_r;
      tag2_r <= tag1_r;
      quo2_r <= prod_q[QUO_SHIFT +: IDX_W];
    end
  end

  // remainder from the registered quotient
  assign prod_m = quo2_r * LINES_K;
  assign rem    = idx2_r - prod_m[IDX_W-1:0];

  assign push          = v2_r && !qstat.full;
  assign push_req.idx  = idx2_r;
  assign push_req.tag  = tag2_r;
  assign push_line     = LINE_W'(rem);

endmodule

// ===== design/dmc_queue.sv =====
// ----------------------------------------------------------------------------
// dmc_queue
// Small register queue between the address split and the tag lookup.
// ----------------------------------------------------------------------------
module dmc_queue import dmc_pkg::*; #(
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output dmc_qstat_t       qstat
);

  logic [WIDTH-1:0]  slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  assign head_data   = slot_r[rd_ptr_r];
  assign qstat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);

endmodule

// ===== design/dmc_back.sv =====
// ----------------------------------------------------------------------------
// dmc_back
// Line store, tag compare and update, saturating totals and result register.
// Clears the valid bits one line per cycle after reset.
// ----------------------------------------------------------------------------
module dmc_back import dmc_pkg::*; #(
  parameter int unsigned MAX_LINES = MAX_LINES_DEF,
  localparam int unsigned LINE_W   = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [LINE_W-1:0] head_line,
  input  dmc_req_t          head_req,
  input  dmc_qstat_t        qstat,
  output logic              pop,
  output logic              clearing,
  dmc_out_if.source         out_if
);

  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(MAX_LINES - 1);

  dmc_line_t mem [MAX_LINES];

  dmc_bk_state_t state_r, state_nxt;
  logic [LINE_W-1:0] clr_idx_r;
  dmc_line_t         rd_q;
  logic [CNT_W-1:0]  hit_total_r, miss_total_r;
  logic [CNT_W-1:0]  hit_total_nxt, miss_total_nxt;

  logic              out_valid_r;
  logic              hit_r, evicted_r;
  logic [IDX_W-1:0]  idx_r;
  logic [TAG_W-1:0]  tag_r;

  logic              out_free;
  logic              hit;
  logic              rd_en;
  logic              commit;
  logic              mem_we;
  logic [LINE_W-1:0] mem_waddr;
  dmc_line_t         mem_wdata;

  assign out_free = !out_valid_r || out_if.ready;
  assign hit      = rd_q.valid && (rd_q.tag == head_req.tag);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR:   if (clr_idx_r == LAST_LINE) state_nxt = BK_LOOKUP;
      BK_LOOKUP:  if (!qstat.empty) state_nxt = BK_COMPARE;
      BK_COMPARE: if (out_free) state_nxt = BK_LOOKUP;
      default:    state_nxt = BK_CLEAR;
    endcase
  end

  always_comb begin
    clearing  = 1'b0;
    rd_en     = 1'b0;
    commit    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = head_line;
    mem_wdata = '{valid: 1'b1, tag: head_req.tag};
    case (state_r)
      BK_CLEAR: begin
        clearing  = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '{valid: 1'b0, tag: '0};
      end
      BK_LOOKUP: begin
        rd_en = !qstat.empty;
      end
      BK_COMPARE: begin
        commit = out_free;
        mem_we = out_free && !hit;
      end
      default: ;
    endcase
  end

  assign pop = commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_CLEAR) clr_idx_r <= clr_idx_r + LINE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= mem[head_line];
  end

  always_comb begin
    hit_total_nxt  = hit_total_r;
    miss_total_nxt = miss_total_r;
    if (commit) begin
      if (hit) hit_total_nxt  = sat_inc(hit_total_r);
      else     miss_total_nxt = sat_inc(miss_total_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_total_r  <= '0;
      miss_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      hit_total_r  <= hit_total_nxt;
      miss_total_r <= miss_total_nxt;
      if (commit) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit_r     <= hit;
      evicted_r <= !hit && rd_q.valid;
      idx_r     <= head_req.idx;
      tag_r     <= head_req.tag;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.hit           = hit_r;
  assign out_if.evicted_valid = evicted_r;
  assign out_if.line_index    = idx_r;
  assign out_if.address_tag   = tag_r;
  assign out_if.hits_so_far   = hit_total_r;
  assign out_if.misses_so_far = miss_total_r;

endmodule

// ===== tb/tb_direct_mapped_cache_tag_lookup_core.sv =====
// ----------------------------------------------------------------------------
// tb_direct_mapped_cache_tag_lookup_core
// Self-checking bench for the direct-mapped cache tag lookup core.
// ----------------------------------------------------------------------------
// Addresses go in on the access channel with random gaps, and results come
// back under random back-pressure. A behavioral copy of the cache (valid
// bits, tags, hit and miss totals) predicts every result, and each result is
// compared field by field in order. Directed accesses cover the reset
// geometry, zero-width and widest fields, clamped register values and writes
// to unused register indexes. Random phases under changing geometries then
// mix re-accesses, same-line conflicts and fully random addresses.
// ----------------------------------------------------------------------------
module tb_direct_mapped_cache_tag_lookup_core import dmc_pkg::*;;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_PHASES = 9;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam int unsigned RECENT_DEPTH = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED = 4'd15;

  typedef struct packed {
    logic             hit;
    logic             evicted_valid;
    logic [IDX_W-1:0] line_index;
    logic [TAG_W-1:0] address_tag;
    logic [CNT_W-1:0] hits_so_far;
    logic [CNT_W-1:0] misses_so_far;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst_n;

  dmc_in_if  in_ch ();
  dmc_cfg_if cfg_ch ();
  dmc_out_if out_ch ();

  direct_mapped_cache_tag_lookup_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .cfg_if (cfg_ch),
    .out_if (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // cache mirror
  logic [CFG_DATA_W-1:0] offset_reg;
  logic [CFG_DATA_W-1:0] index_reg;
  bit                    line_valid [MAX_LINES_DEF];
  logic [TAG_W-1:0]      line_tag [MAX_LINES_DEF];
  logic [CNT_W-1:0]      hit_total;
  logic [CNT_W-1:0]      miss_total;

  lookup_result_t pending_lookups[$];
  logic [31:0]    recent_addrs[$];

  bit no_gaps = 1'b0;
  int mismatches = 0;
  int accesses_sent = 0;
  int cfg_writes = 0;
  int hits_seen = 0;
  int evictions_seen = 0;
  int idle_cycles = 0;

  function automatic int unsigned eff_offset();
    return (offset_reg > OFFSET_MAX) ? OFFSET_MAX : offset_reg;
  endfunction

  function automatic int unsigned eff_index();
    return (index_reg > INDEX_MAX) ? INDEX_MAX : index_reg;
  endfunction

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic void reset_cache_mirror();
    offset_reg = OFFSET_RESET;
    index_reg = INDEX_RESET;
    foreach (line_valid[i]) begin
      line_valid[i] = 1'b0;
      line_tag[i] = '0;
    end
    hit_total = '0;
    miss_total = '0;
  endfunction

  function automatic lookup_result_t cache_lookup(logic [31:0] addr);
    lookup_result_t res;
    int unsigned ob;
    int unsigned ib;
    int unsigned line;
    logic [31:0] idx;
    ob = eff_offset();
    ib = eff_index();
    idx = (addr >> ob) & ((32'd1 << ib) - 32'd1);
    line = idx % MAX_LINES_DEF;
    res.line_index = idx[IDX_W-1:0];
    res.address_tag = addr >> (ob + ib);
    res.hit = line_valid[line] && (line_tag[line] == res.address_tag);
    res.evicted_valid = 1'b0;
    if (res.hit) begin
      if (hit_total != '1) hit_total = hit_total + 1'b1;
    end else begin
      res.evicted_valid = line_valid[line];
      if (miss_total != '1) miss_total = miss_total + 1'b1;
      line_tag[line] = res.address_tag;
      line_valid[line] = 1'b1;
    end
    res.hits_so_far = hit_total;
    res.misses_so_far = miss_total;
    return res;
  endfunction

  function automatic logic [31:0] next_random_address();
    int unsigned ob;
    int unsigned ib;
    int unsigned pick;
    logic [31:0] base;
    logic [31:0] off_mask;
    ob = eff_offset();
    ib = eff_index();
    pick = $urandom_range(0, 99);
    off_mask = (32'd1 << ob) - 32'd1;
    if (recent_addrs.size() == 0 || pick >= 80) return $urandom();
    base = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
    // re-access of a recent line with a fresh byte offset
    if (pick < 45) return (base & ~off_mask) | ($urandom() & off_mask);
    // same line, tag from a small pool
    return (32'($urandom_range(0, 3)) << (ob + ib)) |
           (base & ((32'd1 << (ob + ib)) - 32'd1));
  endfunction

  task automatic send_access(input logic [31:0] addr);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.address <= addr;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_lookups = {pending_lookups, cache_lookup(addr)};
    recent_addrs = {recent_addrs, addr};
    if (recent_addrs.size() > RECENT_DEPTH) void'(recent_addrs.pop_front());
    accesses_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == CFG_OFFSET_BITS) offset_reg = value;
    else if (idx == CFG_INDEX_BITS) index_reg = value;
    cfg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] ob,
                              input logic [CFG_DATA_W-1:0] ib);
    settle();
    write_reg(CFG_OFFSET_BITS, ob);
    write_reg(CFG_INDEX_BITS, ib);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // reset geometry: 16-byte lines, 64 lines
  task automatic test_default_geometry();
    send_access(32'h0000_0000);
    send_access(32'h0000_0000);
    send_access(32'h0000_000F);
    send_access(32'h0000_0010);
    send_access(32'h0000_0400);
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'hFFFF_FFF0);
    send_access(32'h8000_0000);
  endtask

  task automatic test_zero_width_fields();
    set_geometry(4'd0, 4'd0);
    send_access(32'h0000_0001);
    send_access(32'h0000_0001);
    send_access(32'hFFFF_FFFF);
    send_access(32'hFFFF_FFFF);
  endtask

  task automatic test_widest_fields();
    set_geometry(OFFSET_MAX, INDEX_MAX);
    send_access(32'hFFFF_FFFF);
    send_access(32'h003F_FFFF);
    send_access(32'hFFC0_0000);
    send_access(32'h0000_0FFF);
  endtask

  task automatic test_clamped_registers();
    set_geometry(4'd15, 4'd15);
    send_access(32'hFFFF_FFFF);
    send_access(32'h1234_5678);
    set_geometry(4'd13, 4'd11);
    send_access(32'h1234_5678);
    send_access(32'hA5A5_5A5A);
  endtask

  task automatic test_unused_registers();
    set_geometry(4'd2, 4'd3);
    write_reg(CFG_FIRST_UNUSED, 4'hF);
    write_reg(CFG_LAST_UNUSED, 4'h0);
    write_reg(4'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)), 4'($urandom()));
    send_access(32'h0000_0024);
    send_access(32'h0000_0027);
  endtask

  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] ob;
    logic [CFG_DATA_W-1:0] ib;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      ob = (phase == 0) ? OFFSET_RESET : 4'($urandom_range(0, 15));
      ib = (phase == 0) ? INDEX_RESET : 4'($urandom_range(0, 15));
      set_geometry(ob, ib);
      if ($urandom_range(0, 2) == 0)
        write_reg(4'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)), 4'($urandom()));
      no_gaps = (phase % 3 == 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_access(next_random_address());
      no_gaps = 1'b0;
    end
  endtask

  initial begin : result_monitor
    lookup_result_t got;
    lookup_result_t want;
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.hit = out_ch.hit;
      got.evicted_valid = out_ch.evicted_valid;
      got.line_index = out_ch.line_index;
      got.address_tag = out_ch.address_tag;
      got.hits_so_far = out_ch.hits_so_far;
      got.misses_so_far = out_ch.misses_so_far;
      if (got.hit === 1'b1) hits_seen++;
      if (got.evicted_valid === 1'b1) evictions_seen++;
      if (pending_lookups.size() == 0) begin
        $error("result item with no access outstanding");
        mismatches++;
      end else begin
        want = pending_lookups.pop_front();
        check_field("hit", want.hit, got.hit);
        check_field("evicted_valid", want.evicted_valid, got.evicted_valid);
        check_field("line_index", want.line_index, got.line_index);
        check_field("address_tag", want.address_tag, got.address_tag);
        check_field("hits_so_far", want.hits_so_far, got.hits_so_far);
        check_field("misses_so_far", want.misses_so_far, got.misses_so_far);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.address = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    reset_cache_mirror();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_default_geometry();
    test_zero_width_fields();
    test_widest_fields();
    test_clamped_registers();
    test_unused_registers();
    test_random_traffic();
    settle();

    $display("accesses: %0d, register writes: %0d", accesses_sent, cfg_writes);
    $display("hits observed: %0d, evictions observed: %0d, mismatches: %0d",
             hits_seen, evictions_seen, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
